[sv/rhc_pkg.sv]
// Shared types and constants for the RGB/HSL colour converter.
// Used by every module of the converter; depends on nothing.
package rhc_pkg;

   localparam int FRAC = 16;                 // fractional bits of hue, sat, light
   localparam int QW   = FRAC + 1;           // width of a Q1.FRAC value
   localparam logic [QW-1:0] ONE  = QW'(1) << FRAC;
   localparam logic [QW-1:0] HALF = QW'(1) << (FRAC - 1);

   // ceil(2^32 / 255): sum * 2^16 / 510 == (sum * RECIP_255) >> 17 for sum <= 510
   localparam logic [24:0] RECIP_255 = 25'd16843010;

   typedef enum logic [1:0] {
      OP_TO_HSL   = 2'd0,
      OP_TO_RGB   = 2'd1,
      OP_RECOLOUR = 2'd2,
      OP_ECHO     = 2'd3
   } op_type;

   localparam logic [2:0] SEC_RED_UP     = 3'd0;
   localparam logic [2:0] SEC_RED_DOWN   = 3'd1;
   localparam logic [2:0] SEC_GREEN_UP   = 3'd2;
   localparam logic [2:0] SEC_GREEN_DOWN = 3'd3;
   localparam logic [2:0] SEC_BLUE_UP    = 3'd4;

   typedef struct packed {
      op_type            opcode;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [FRAC-1:0]   hue;
      logic [QW-1:0]     sat;
      logic [QW-1:0]     light;
   } pix_type;

   // partial quotients of the hue and saturation divisions
   typedef struct packed {
      logic [10:0]       hrem;
      logic [10:0]       hden;
      logic [FRAC-1:0]   hq;
      logic [8:0]        srem;
      logic [8:0]        sden;
      logic [FRAC-1:0]   sq;
   } div_type;

   typedef struct packed {
      pix_type           pix;
      logic              grey;
      logic              sfull;
      logic [QW-1:0]     lf;
   } side_type;

   typedef struct packed {
      pix_type           pix;
      logic              use_inv;
   } inv_type;

endpackage

[sv/rhc_fwd.sv]
// Forward front end: max/min, lightness, and divider set-up.
// Depends on rhc_pkg.
module rhc_fwd (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  rhc_pkg::pix_type  pix_in,
   output logic              valid_out,
   output rhc_pkg::div_type  div_out,
   output rhc_pkg::side_type side_out
);

   localparam logic [24:0] RECIP_255_W = rhc_pkg::RECIP_255;

   logic              valid_ff;
   rhc_pkg::div_type  div_ff, div_in;
   rhc_pkg::side_type side_ff, side_in;

   logic [7:0]         mx, mn, dl;
   logic [8:0]         sum, den;
   logic signed [11:0] num;
   logic [10:0]        d6;
   logic [33:0]        lprod;

   always_comb begin
      mx = pix_in.red;
      mn = pix_in.red;
      if (pix_in.green > mx) mx = pix_in.green;
      if (pix_in.blue  > mx) mx = pix_in.blue;
      if (pix_in.green < mn) mn = pix_in.green;
      if (pix_in.blue  < mn) mn = pix_in.blue;
      sum = {1'b0, mx} + {1'b0, mn};
      dl  = mx - mn;
      den = (sum < 9'd255) ? sum : (9'd510 - sum);
      d6  = ({3'b0, dl} << 2) + ({3'b0, dl} << 1);
      if (pix_in.red == mx)
         num = $signed({4'b0, pix_in.green}) - $signed({4'b0, pix_in.blue});
      else if (pix_in.green == mx)
         num = $signed({3'b0, dl, 1'b0}) + $signed({4'b0, pix_in.blue})
             - $signed({4'b0, pix_in.red});
      else
         num = $signed({2'b0, dl, 2'b0}) + $signed({4'b0, pix_in.red})
             - $signed({4'b0, pix_in.green});
      if (num < 0) num = num + $signed({1'b0, d6});
      lprod = {25'b0, sum} * {9'b0, RECIP_255_W};

      div_in.hrem = num[10:0];
      div_in.hden = d6;
      div_in.hq   = '0;
      div_in.sden = den;
      div_in.srem = ({1'b0, dl} == den) ? 9'd0 : {1'b0, dl};
      div_in.sq   = '0;

      side_in.pix   = pix_in;
      side_in.grey  = (dl == 8'd0);
      side_in.sfull = ({1'b0, dl} == den);
      side_in.lf    = lprod[33:17];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      div_ff  <= div_in;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign div_out   = div_ff;
   assign side_out  = side_ff;

endmodule

[sv/rhc_div_step.sv]
// One registered restoring step of the hue and saturation dividers.
// Depends on rhc_pkg.
module rhc_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  rhc_pkg::div_type  div_in,
   input  rhc_pkg::side_type side_in,
   output logic              valid_out,
   output rhc_pkg::div_type  div_out,
   output rhc_pkg::side_type side_out
);

   logic              valid_ff;
   rhc_pkg::div_type  div_ff, div_nx;
   rhc_pkg::side_type side_ff;
   logic [11:0]       ht;
   logic [9:0]        st;

   always_comb begin
      div_nx = div_in;
      ht = {div_in.hrem, 1'b0};
      st = {div_in.srem, 1'b0};
      if (ht >= {1'b0, div_in.hden}) begin
         div_nx.hrem = 11'(ht - {1'b0, div_in.hden});
         div_nx.hq   = {div_in.hq[rhc_pkg::FRAC-2:0], 1'b1};
      end else begin
         div_nx.hrem = ht[10:0];
         div_nx.hq   = {div_in.hq[rhc_pkg::FRAC-2:0], 1'b0};
      end
      if (st >= {1'b0, div_in.sden}) begin
         div_nx.srem = 9'(st - {1'b0, div_in.sden});
         div_nx.sq   = {div_in.sq[rhc_pkg::FRAC-2:0], 1'b1};
      end else begin
         div_nx.srem = st[8:0];
         div_nx.sq   = {div_in.sq[rhc_pkg::FRAC-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      div_ff  <= div_nx;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign div_out   = div_ff;
   assign side_out  = side_ff;

endmodule

[sv/rhc_inv.sv]
// HSL to RGB back end: five stages, sextant method, byte scaling.
// Depends on rhc_pkg.
module rhc_inv (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   input  rhc_pkg::inv_type inv_in,
   output logic             valid_out,
   output rhc_pkg::pix_type pix_out
);

   localparam int QW = rhc_pkg::QW;
   localparam int F  = rhc_pkg::FRAC;

   logic [4:0]       valid_ff;
   rhc_pkg::inv_type p1_ff, p2_ff, p3_ff, p4_ff;
   rhc_pkg::pix_type out_ff, out_in;

   // stage 1
   logic [QW-1:0]   ss_in, ll_in, ss_ff, ll_ff;
   logic [2*QW-1:0] ls_ff;
   // stage 2
   logic [32:0]     v2_in, m2_in, dd_in, v2_ff, m2_ff, dd_ff, lone_ff;
   logic [33:0]     m2w;
   logic [F+2:0]    h6;
   logic [2:0]      sec_ff, sec3_ff;
   logic [F-1:0]    fr_ff;
   // stage 3
   logic [32:0]     phi_ff, v23_ff, m23_ff, lone3_ff;
   logic [31:0]     plo_ff;
   logic            zero_ff;
   // stage 4
   logic [32:0]     vsf, mid1, mid2, cr_in, cg_in, cb_in, cr_ff, cg_ff, cb_ff;

   function automatic logic [7:0] to_byte(input logic [32:0] c);
      logic [40:0] t;
      t = ({c, 8'b0}) - {8'b0, c};
      return (t[40:32] > 9'd255) ? 8'd255 : t[39:32];
   endfunction

   always_comb begin
      ss_in = (inv_in.pix.sat   > rhc_pkg::ONE) ? rhc_pkg::ONE : inv_in.pix.sat;
      ll_in = (inv_in.pix.light > rhc_pkg::ONE) ? rhc_pkg::ONE : inv_in.pix.light;

      if (ll_ff <= rhc_pkg::HALF)
         v2_in = 33'({ll_ff, 16'b0}) + 33'(ls_ff);
      else
         v2_in = 33'({ll_ff, 16'b0}) + 33'({ss_ff, 16'b0}) - 33'(ls_ff);
      m2w   = {ll_ff, 17'b0} - {1'b0, v2_in};
      m2_in = m2w[32:0];
      dd_in = v2_in - m2_in;
      h6    = ({3'b0, p1_ff.pix.hue} << 2) + ({3'b0, p1_ff.pix.hue} << 1);

      vsf  = phi_ff + {17'b0, plo_ff[31:16]};
      mid1 = m23_ff + vsf;
      mid2 = v23_ff - vsf;
      cr_in = lone3_ff;
      cg_in = lone3_ff;
      cb_in = lone3_ff;
      if (!zero_ff) begin
         case (sec3_ff)
            rhc_pkg::SEC_RED_UP:     begin cr_in = v23_ff; cg_in = mid1;   cb_in = m23_ff; end
            rhc_pkg::SEC_RED_DOWN:   begin cr_in = mid2;   cg_in = v23_ff; cb_in = m23_ff; end
            rhc_pkg::SEC_GREEN_UP:   begin cr_in = m23_ff; cg_in = v23_ff; cb_in = mid1;   end
            rhc_pkg::SEC_GREEN_DOWN: begin cr_in = m23_ff; cg_in = mid2;   cb_in = v23_ff; end
            rhc_pkg::SEC_BLUE_UP:    begin cr_in = mid1;   cg_in = m23_ff; cb_in = v23_ff; end
            default:                 begin cr_in = v23_ff; cg_in = m23_ff; cb_in = mid2;   end
         endcase
      end

      out_in = p4_ff.pix;
      if (p4_ff.use_inv) begin
         out_in.red   = to_byte(cr_ff);
         out_in.green = to_byte(cg_ff);
         out_in.blue  = to_byte(cb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= {valid_ff[3:0], valid_in};
      // stage 1
      p1_ff <= inv_in;
      ss_ff <= ss_in;
      ll_ff <= ll_in;
      ls_ff <= {{QW{1'b0}}, ss_in} * {{QW{1'b0}}, ll_in};
      // stage 2
      p2_ff   <= p1_ff;
      v2_ff   <= v2_in;
      m2_ff   <= m2_in;
      dd_ff   <= dd_in;
      lone_ff <= 33'({ll_ff, 16'b0});
      sec_ff  <= h6[F+2:F];
      fr_ff   <= h6[F-1:0];
      // stage 3
      p3_ff    <= p2_ff;
      phi_ff   <= {16'b0, dd_ff[32:16]} * {17'b0, fr_ff};
      plo_ff   <= {16'b0, dd_ff[15:0]} * {16'b0, fr_ff};
      v23_ff   <= v2_ff;
      m23_ff   <= m2_ff;
      lone3_ff <= lone_ff;
      sec3_ff  <= sec_ff;
      zero_ff  <= (v2_ff == 33'd0);
      // stage 4
      p4_ff <= p3_ff;
      cr_ff <= cr_in;
      cg_ff <= cg_in;
      cb_ff <= cb_in;
      // stage 5
      out_ff <= out_in;
   end

   assign valid_out = valid_ff[4];
   assign pix_out   = out_ff;

endmodule

[sv/rgb_hsl_color_converter_core.sv]
// RGB/HSL colour converter, fully pipelined, one pixel per clock.
// Pipeline: 24 register stages, namely the input register, the front end, the
// divider steps, the opcode select register and the back end; rsp_valid is the last.
// Throughput: one transfer per cycle, set by the 16-step divider chain
// and the 5-stage HSL-to-RGB back end, all one stage per clock.
// busy is always low; the receiver cannot stall, results are strobed once.
// Synchronous active-high reset clears the valid bits only; no other state.
module rgb_hsl_color_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [15:0] req_hue_in,
   input  logic [16:0] req_sat_in,
   input  logic [16:0] req_light_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [15:0] rsp_hue_out,
   output logic [16:0] rsp_sat_out,
   output logic [16:0] rsp_light_out
);

   localparam int STEPS = rhc_pkg::FRAC;

   // input register
   logic             in_valid_ff;
   rhc_pkg::pix_type in_pix_ff, in_pix_in;

   // divider chain: index 0 is the forward front end output
   logic              dv_valid [STEPS+1];
   rhc_pkg::div_type  dv_div   [STEPS+1];
   rhc_pkg::side_type dv_side  [STEPS+1];

   // opcode select stage
   logic             sel_valid_ff;
   rhc_pkg::inv_type sel_ff, sel_in;
   logic [15:0]      hf;
   logic [16:0]      sf;

   logic             out_valid;
   rhc_pkg::pix_type out_pix;

   assign busy = 1'b0;   // accepts a transfer on every cycle

   always_comb begin
      in_pix_in.opcode = rhc_pkg::op_type'(req_opcode);
      in_pix_in.red    = req_red_in;
      in_pix_in.green  = req_green_in;
      in_pix_in.blue   = req_blue_in;
      in_pix_in.hue    = req_hue_in;
      in_pix_in.sat    = req_sat_in;
      in_pix_in.light  = req_light_in;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= start;
      in_pix_ff <= in_pix_in;
   end

   // max/min, lightness by reciprocal multiply, divider set-up
   rhc_fwd u_fwd (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (in_valid_ff),
      .pix_in    (in_pix_ff),
      .valid_out (dv_valid[0]),
      .div_out   (dv_div[0]),
      .side_out  (dv_side[0])
   );

   // one quotient bit of hue and saturation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_div
      rhc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (dv_valid[i]),
         .div_in    (dv_div[i]),
         .side_in   (dv_side[i]),
         .valid_out (dv_valid[i+1]),
         .div_out   (dv_div[i+1]),
         .side_out  (dv_side[i+1])
      );
   end

   // Pick the final HSL per opcode. When the back end runs, its operands are
   // exactly the final HSL fields: input HSL for to-RGB, hue_in with the
   // computed saturation and lightness for a recolour.
   always_comb begin
      hf = dv_side[STEPS].grey ? '0 : dv_div[STEPS].hq;
      if (dv_side[STEPS].grey)       sf = '0;
      else if (dv_side[STEPS].sfull) sf = rhc_pkg::ONE;
      else                           sf = {1'b0, dv_div[STEPS].sq};

      sel_in.pix     = dv_side[STEPS].pix;
      sel_in.use_inv = 1'b0;
      case (dv_side[STEPS].pix.opcode)
         rhc_pkg::OP_TO_HSL: begin
            sel_in.pix.hue   = hf;
            sel_in.pix.sat   = sf;
            sel_in.pix.light = dv_side[STEPS].lf;
         end
         rhc_pkg::OP_TO_RGB: begin
            sel_in.use_inv = 1'b1;
         end
         rhc_pkg::OP_RECOLOUR: begin
            sel_in.pix.sat   = sf;
            sel_in.pix.light = dv_side[STEPS].lf;
            sel_in.use_inv   = 1'b1;
         end
         default: begin
            sel_in.use_inv = 1'b0;   // echo opcode, pixel passed through unchanged
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) sel_valid_ff <= 1'b0;
      else       sel_valid_ff <= dv_valid[STEPS];
      sel_ff <= sel_in;
   end

   // HSL to RGB back end, result registers at its end
   rhc_inv u_inv (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sel_valid_ff),
      .inv_in    (sel_ff),
      .valid_out (out_valid),
      .pix_out   (out_pix)
   );

   assign rsp_valid     = out_valid;
   assign rsp_red_out   = out_pix.red;
   assign rsp_green_out = out_pix.green;
   assign rsp_blue_out  = out_pix.blue;
   assign rsp_hue_out   = out_pix.hue;
   assign rsp_sat_out   = out_pix.sat;
   assign rsp_light_out = out_pix.light;

endmodule
